// ===== hdl/moving_box_contact_interval_assert.svh =====
// Assertion macros for the moving box contact interval block.
// Depends on nothing; included by the top level.
`ifndef MOVING_BOX_CONTACT_INTERVAL_ASSERT_SVH
`define MOVING_BOX_CONTACT_INTERVAL_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define MBCI_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication outside reset.
`define MBCI_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== hdl/mbci_pkg.sv =====
// Package for the moving box contact interval block: beat types and constants.
// Depends on nothing.
package mbci_pkg;
    localparam int CoordBits = 16;
    localparam int FracBits = 16;
    localparam int TimeBits = FracBits + 1;
    localparam int DiffBits = CoordBits + 1;
    // Numerator shifted by the fraction bits.
    localparam int NumBits = DiffBits + FracBits;
    localparam logic [TimeBits-1:0] TimeOne = TimeBits'(1) << FracBits;
    localparam logic [TimeBits-1:0] TimeSat = TimeOne + TimeBits'(1);
    // One divider stage per quotient bit, quotient kept to TimeBits+1 bits.
    localparam int QBits = TimeBits + 1;

    typedef struct packed {
        logic signed [CoordBits-1:0] first_min_x;
        logic signed [CoordBits-1:0] first_min_y;
        logic signed [CoordBits-1:0] first_max_x;
        logic signed [CoordBits-1:0] first_max_y;
        logic signed [CoordBits-1:0] second_min_x;
        logic signed [CoordBits-1:0] second_min_y;
        logic signed [CoordBits-1:0] second_max_x;
        logic signed [CoordBits-1:0] second_max_y;
        logic signed [CoordBits-1:0] first_vel_x;
        logic signed [CoordBits-1:0] first_vel_y;
        logic signed [CoordBits-1:0] second_vel_x;
        logic signed [CoordBits-1:0] second_vel_y;
    } in_beat_t;

    typedef struct packed {
        logic                hit;
        logic [TimeBits-1:0] first_contact_time;
        logic [TimeBits-1:0] last_contact_time;
    } out_beat_t;

    // Per-item control carried along the divider pipeline.
    typedef struct packed {
        logic touch;
        logic miss;
        logic [3:0] use_q;   // x first, x last, y first, y last
    } ctl_t;
endpackage

// ===== hdl/mbci_div.sv =====
// Pipelined restoring divider array: four quotients, one quotient bit per stage.
// Depends on mbci_pkg.
module mbci_div (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  mbci_pkg::ctl_t in_ctl,
    input  logic [4*mbci_pkg::DiffBits-1:0] in_num,
    input  logic [4*mbci_pkg::DiffBits-1:0] in_den,
    output logic out_valid,
    output mbci_pkg::ctl_t out_ctl,
    output logic [4*mbci_pkg::TimeBits-1:0] out_q
);
    localparam int D = mbci_pkg::DiffBits;
    localparam int N = mbci_pkg::NumBits;
    localparam int Q = mbci_pkg::QBits;
    localparam int T = mbci_pkg::TimeBits;
    // Stage s handles quotient bit Q-1-s; remainder held at D+1 bits.
    logic valid_reg [1:Q];
    mbci_pkg::ctl_t ctl_reg [1:Q];
    logic [D:0] rem_reg [1:Q][4];
    logic [Q-1:0] num_reg [1:Q][4];
    logic [D-1:0] den_reg [1:Q][4];
    logic [Q-1:0] q_reg [1:Q][4];

    // Seed the remainder with the numerator bits above the quotient range; when
    // they already reach the divisor the quotient is far above 1.0, so flag it.
    logic [N-1:0] num_seed [4];
    logic [D:0] rem_seed [4];
    logic [Q-1:0] q_seed [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            num_seed[l] = {in_num[l*D +: D], {mbci_pkg::FracBits{1'b0}}};
            rem_seed[l] = {{(D+1-(N-Q)){1'b0}}, num_seed[l][N-1:Q]};
            q_seed[l] = {rem_seed[l] >= {1'b0, in_den[l*D +: D]}, {(Q-1){1'b0}}};
        end
    end

    for (genvar s = 0; s < Q; s++) begin : g_st
        localparam int B = Q - 1 - s;
        logic v_in;
        mbci_pkg::ctl_t c_in;
        logic [D:0] r_in [4];
        logic [Q-1:0] n_in [4];
        logic [D-1:0] d_in [4];
        logic [Q-1:0] q_in [4];

        if (s == 0) begin : g_head
            always_comb
            begin
                v_in = in_valid;
                c_in = in_ctl;
                for (int l = 0; l < 4; l++)
                begin
                    r_in[l] = rem_seed[l];
                    n_in[l] = num_seed[l][Q-1:0];
                    d_in[l] = in_den[l*D +: D];
                    q_in[l] = q_seed[l];
                end
            end
        end
        else begin : g_body
            always_comb
            begin
                v_in = valid_reg[s];
                c_in = ctl_reg[s];
                for (int l = 0; l < 4; l++)
                begin
                    r_in[l] = rem_reg[s][l];
                    n_in[l] = num_reg[s][l];
                    d_in[l] = den_reg[s][l];
                    q_in[l] = q_reg[s][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s+1] <= 1'b0;
            else
                valid_reg[s+1] <= v_in;
        end
        always_ff @(posedge clk)
        begin
            ctl_reg[s+1] <= c_in;
            for (int l = 0; l < 4; l++)
            begin
                logic [D+1:0] trial;
                logic [D+1:0] sh;
                logic [Q-1:0] qn;
                sh = {r_in[l], n_in[l][B]};
                trial = sh - {2'b00, d_in[l]};
                qn = q_in[l];
                num_reg[s+1][l] <= n_in[l];
                den_reg[s+1][l] <= d_in[l];
                if (!trial[D+1] && (d_in[l] != '0))
                begin
                    rem_reg[s+1][l] <= trial[D:0];
                    qn[B] = 1'b1;
                end
                else
                    rem_reg[s+1][l] <= sh[D:0];
                // Any bit that would overflow the remainder means quotient above range.
                if (sh[D+1])
                    qn[Q-1] = 1'b1;
                q_reg[s+1][l] <= qn;
            end
        end
    end

    assign out_valid = valid_reg[Q];
    assign out_ctl = ctl_reg[Q];
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (den_reg[Q][l] == '0 || q_reg[Q][l] > Q'(mbci_pkg::TimeOne))
                out_q[l*T +: T] = mbci_pkg::TimeSat;
            else
                out_q[l*T +: T] = q_reg[Q][l][T-1:0];
        end
    end
endmodule

// ===== hdl/moving_box_contact_interval.sv =====
// Top level of the moving box contact interval block.
// Depends on mbci_pkg, mbci_div and moving_box_contact_interval_assert.svh.
//
//  channel  | signals               | flow
//  ---------+-----------------------+--------------------------------------
//  request  | start, busy, req      | beat taken when start && !busy
//  result   | done, rsp             | one-cycle strobe, receiver cannot stall
//
// One beat enters each cycle; busy is tied low since nothing can stall.
// Times are Q1.16. The pipeline has one setup stage, one stage per
// quotient bit of the restoring divider array, and two merge stages.
// Reset clears valid bits only; payload registers take no reset.
module moving_box_contact_interval (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  mbci_pkg::in_beat_t req,
    output logic done,
    output mbci_pkg::out_beat_t rsp
);
    localparam int D = mbci_pkg::DiffBits;
    localparam int T = mbci_pkg::TimeBits;

    typedef logic signed [D-1:0] diff_t;

    // Setup stage: overlap test, per-axis miss and numerator/denominator pick.
    logic s1_valid_reg;
    mbci_pkg::ctl_t s1_ctl_reg;
    logic [4*D-1:0] s1_num_reg;
    logic [4*D-1:0] s1_den_reg;

    function automatic diff_t sx(input logic signed [mbci_pkg::CoordBits-1:0] v);
        return diff_t'(v);
    endfunction

    function automatic diff_t absd(input diff_t v);
        return v[D-1] ? -v : v;
    endfunction

    logic ov_x, ov_y, touch_c, miss_c;
    logic [3:0] use_c;
    logic [4*D-1:0] num_c, den_c;

    always_comb
    begin
        diff_t amin [2];
        diff_t amax [2];
        diff_t bmin [2];
        diff_t bmax [2];
        diff_t rel [2];
        amin[0] = sx(req.first_min_x);  amin[1] = sx(req.first_min_y);
        amax[0] = sx(req.first_max_x);  amax[1] = sx(req.first_max_y);
        bmin[0] = sx(req.second_min_x); bmin[1] = sx(req.second_min_y);
        bmax[0] = sx(req.second_max_x); bmax[1] = sx(req.second_max_y);
        rel[0] = sx(req.second_vel_x) - sx(req.first_vel_x);
        rel[1] = sx(req.second_vel_y) - sx(req.first_vel_y);
        ov_x = !(amax[0] < bmin[0] || amin[0] > bmax[0]);
        ov_y = !(amax[1] < bmin[1] || amin[1] > bmax[1]);
        touch_c = ov_x && ov_y;
        miss_c = 1'b0;
        use_c = '0;
        num_c = '0;
        den_c = '0;
        for (int i = 0; i < 2; i++)
        begin
            den_c[(2*i)*D +: D] = absd(rel[i]);
            den_c[(2*i+1)*D +: D] = absd(rel[i]);
            if (rel[i] < 0)
            begin
                if (bmax[i] < amin[i]) miss_c = 1'b1;
                use_c[2*i] = amax[i] < bmin[i];
                num_c[(2*i)*D +: D] = absd(amax[i] - bmin[i]);
                use_c[2*i+1] = bmax[i] > amin[i];
                num_c[(2*i+1)*D +: D] = absd(amin[i] - bmax[i]);
            end
            else
            begin
                if (bmin[i] > amax[i]) miss_c = 1'b1;
                use_c[2*i] = bmax[i] < amin[i];
                num_c[(2*i)*D +: D] = absd(amin[i] - bmax[i]);
                use_c[2*i+1] = amax[i] > bmin[i];
                num_c[(2*i+1)*D +: D] = absd(amax[i] - bmin[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_ctl_reg <= '{touch: touch_c, miss: miss_c, use_q: use_c};
        s1_num_reg <= num_c;
        s1_den_reg <= den_c;
    end

    assign busy = 1'b0;

    logic dv;
    mbci_pkg::ctl_t dctl;
    logic [4*T-1:0] dq;

    mbci_div u_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s1_valid_reg), .in_ctl(s1_ctl_reg),
        .in_num(s1_num_reg), .in_den(s1_den_reg),
        .out_valid(dv), .out_ctl(dctl), .out_q(dq)
    );

    // Merge stage 1: fold the x axis.
    logic m1_valid_reg;
    mbci_pkg::ctl_t m1_ctl_reg;
    logic m1_fail_reg;
    logic [T-1:0] m1_first_reg, m1_last_reg, m1_qf_reg, m1_ql_reg;
    logic [T-1:0] m1_f_c, m1_l_c;

    always_comb
    begin : fold_x
        logic [T-1:0] f, l;
        f = dctl.use_q[0] ? dq[0 +: T] : '0;
        l = (dctl.use_q[1] && dq[T +: T] < mbci_pkg::TimeOne) ? dq[T +: T]
                                                                : mbci_pkg::TimeOne;
        m1_f_c = f;
        m1_l_c = l;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_valid_reg <= 1'b0;
        else
            m1_valid_reg <= dv;
    end

    always_ff @(posedge clk)
    begin
        m1_ctl_reg <= dctl;
        m1_first_reg <= m1_f_c;
        m1_last_reg <= m1_l_c;
        m1_fail_reg <= m1_f_c > m1_l_c;
        m1_qf_reg <= dq[2*T +: T];
        m1_ql_reg <= dq[3*T +: T];
    end

    // Merge stage 2: fold the y axis and form the result beat.
    logic done_reg;
    mbci_pkg::out_beat_t rsp_reg;
    mbci_pkg::out_beat_t rsp_c;

    always_comb
    begin : fold_y
        logic [T-1:0] f, l;
        f = m1_first_reg;
        l = m1_last_reg;
        if (m1_ctl_reg.use_q[2] && m1_qf_reg > f) f = m1_qf_reg;
        if (m1_ctl_reg.use_q[3] && m1_ql_reg < l) l = m1_ql_reg;
        rsp_c = '0;
        if (m1_ctl_reg.touch)
            rsp_c.hit = 1'b1;
        else if (!m1_ctl_reg.miss && !m1_fail_reg && !(f > l))
        begin
            rsp_c.hit = 1'b1;
            rsp_c.first_contact_time = f;
            rsp_c.last_contact_time = l;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= m1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_c;
    end

    assign done = done_reg;
    assign rsp = rsp_reg;

`include "moving_box_contact_interval_assert.svh"

    // A hit never reports a first time after the last time.
    `MBCI_ASSERT_IMP(a_order, clk, rst_n, done,
        rsp.first_contact_time <= rsp.last_contact_time)
    // A miss reports both times as zero.
    `MBCI_ASSERT_IMP(a_miss_zero, clk, rst_n, done && !rsp.hit,
        rsp.first_contact_time == '0 && rsp.last_contact_time == '0)
    // Merge stage 1 always produces a strobe in the next cycle.
    `MBCI_ASSERT_NXT(a_flow, clk, rst_n, m1_valid_reg, done)
endmodule

// ===== tb/sv/mbci_checker.sv =====
// Checker for the moving box contact interval block: predicts each result beat
// from the accepted request beat and compares in order. Depends on mbci_pkg.
module mbci_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  mbci_pkg::in_beat_t  req,
    input  logic                done,
    input  mbci_pkg::out_beat_t rsp,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TOne = longint'(1) << mbci_pkg::FracBits;
    localparam longint TSat = TOne + 1;

    mbci_pkg::out_beat_t contact_q[$];
    int                  mismatches;

    function automatic longint contact_quot(longint num, longint den);
        longint n;
        longint d;
        longint q;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        if (d == 0)
            return TSat;
        q = (n << mbci_pkg::FracBits) / d;
        return (q > TOne) ? TSat : q;
    endfunction

    function automatic mbci_pkg::out_beat_t predict_contact(mbci_pkg::in_beat_t b);
        longint              amin[2], amax[2], bmin[2], bmax[2], rel[2];
        longint              tfirst, tlast, q;
        mbci_pkg::out_beat_t r;
        amin[0] = b.first_min_x;   amin[1] = b.first_min_y;
        amax[0] = b.first_max_x;   amax[1] = b.first_max_y;
        bmin[0] = b.second_min_x;  bmin[1] = b.second_min_y;
        bmax[0] = b.second_max_x;  bmax[1] = b.second_max_y;
        rel[0] = longint'(b.second_vel_x) - longint'(b.first_vel_x);
        rel[1] = longint'(b.second_vel_y) - longint'(b.first_vel_y);
        r = '0;
        tfirst = 0;
        tlast = TOne;
        if (!(amax[0] < bmin[0] || amin[0] > bmax[0]) &&
            !(amax[1] < bmin[1] || amin[1] > bmax[1]))
        begin
            r.hit = 1'b1;
            return r;
        end
        for (int i = 0; i < 2; i++)
        begin
            if (rel[i] < 0)
            begin
                if (bmax[i] < amin[i])
                    return r;
                if (amax[i] < bmin[i])
                begin
                    q = contact_quot(amax[i] - bmin[i], rel[i]);
                    if (q > tfirst) tfirst = q;
                end
                if (bmax[i] > amin[i])
                begin
                    q = contact_quot(amin[i] - bmax[i], rel[i]);
                    if (q < tlast) tlast = q;
                end
            end
            else
            begin
                if (bmin[i] > amax[i])
                    return r;
                if (bmax[i] < amin[i])
                begin
                    q = contact_quot(amin[i] - bmax[i], rel[i]);
                    if (q > tfirst) tfirst = q;
                end
                if (amax[i] > bmin[i])
                begin
                    q = contact_quot(amax[i] - bmin[i], rel[i]);
                    if (q < tlast) tlast = q;
                end
            end
            if (tfirst > tlast)
                return r;
        end
        r.hit = 1'b1;
        r.first_contact_time = tfirst[mbci_pkg::TimeBits-1:0];
        r.last_contact_time = tlast[mbci_pkg::TimeBits-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        mbci_pkg::out_beat_t want;
        if (rst_n)
        begin
            if (start && !busy)
                contact_q.push_back(predict_contact(req));
            if (done)
            begin
                if (contact_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %p", rsp);
                end
                else
                begin
                    want = contact_q.pop_front();
                    if (rsp.hit !== want.hit ||
                        rsp.first_contact_time !== want.first_contact_time ||
                        rsp.last_contact_time !== want.last_contact_time)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, rsp);
                    end
                end
            end
        end
        pending = contact_q.size();
    end

    initial pending = 0;

    assign fail_count = mismatches;
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the moving box contact interval testbench: clock, reset, request
// stimulus and verdict. Depends on mbci_pkg, mbci_checker and the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CoordBits = mbci_pkg::CoordBits;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    mbci_pkg::in_beat_t  req;
    logic                done;
    mbci_pkg::out_beat_t rsp;
    int                  fail_count;
    int                  pending;

    moving_box_contact_interval u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    mbci_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Hold a beat on the bus until the block takes it, then idle a random
    // number of cycles. start stays high across back-to-back beats.
    task automatic send_beat(mbci_pkg::in_beat_t b);
        int gap;
        start <= 1'b1;
        req <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = $urandom_range(0, 5);
        // Leave stretches with no idling at all.
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [CoordBits-1:0] rand_coord(int spread);
        case (spread)
            0:       return CoordBits'($urandom);
            1:       return CoordBits'($signed($urandom_range(0, 1023)) - 512);
            default: return CoordBits'($signed($urandom_range(0, 63)) - 32);
        endcase
    endfunction

    // Box pair with content that often reaches the per-axis sweep: moderate
    // coordinates, occasional full-range corners or velocities.
    function automatic mbci_pkg::in_beat_t rand_pair();
        mbci_pkg::in_beat_t b;
        int                 s;
        s = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        b.first_min_x = rand_coord(s);
        b.first_min_y = rand_coord(s);
        b.first_max_x = CoordBits'(b.first_min_x + rand_coord(2) + 32);
        b.first_max_y = CoordBits'(b.first_min_y + rand_coord(2) + 32);
        b.second_min_x = rand_coord(s);
        b.second_min_y = rand_coord(s);
        b.second_max_x = CoordBits'(b.second_min_x + rand_coord(2) + 32);
        b.second_max_y = CoordBits'(b.second_min_y + rand_coord(2) + 32);
        if ($urandom_range(0, 7) == 0)
        begin
            // Noise: raw full-range fields, inverted boxes included.
            b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return b;
        end
        b.first_vel_x = $urandom_range(0, 4) == 0 ? 16'sd0 : rand_coord(s == 0 ? 0 : 1);
        b.first_vel_y = $urandom_range(0, 4) == 0 ? 16'sd0 : rand_coord(s == 0 ? 0 : 1);
        b.second_vel_x = $urandom_range(0, 4) == 0 ? b.first_vel_x : rand_coord(1);
        b.second_vel_y = $urandom_range(0, 4) == 0 ? b.first_vel_y : rand_coord(1);
        return b;
    endfunction

    function automatic mbci_pkg::in_beat_t make_pair(
        int ax0, int ay0, int ax1, int ay1, int bx0, int by0, int bx1, int by1,
        int avx, int avy, int bvx, int bvy);
        mbci_pkg::in_beat_t b;
        b.first_min_x = CoordBits'(ax0);   b.first_min_y = CoordBits'(ay0);
        b.first_max_x = CoordBits'(ax1);   b.first_max_y = CoordBits'(ay1);
        b.second_min_x = CoordBits'(bx0);  b.second_min_y = CoordBits'(by0);
        b.second_max_x = CoordBits'(bx1);  b.second_max_y = CoordBits'(by1);
        b.first_vel_x = CoordBits'(avx);   b.first_vel_y = CoordBits'(avy);
        b.second_vel_x = CoordBits'(bvx);  b.second_vel_y = CoordBits'(bvy);
        return b;
    endfunction

    initial
    begin
        int cycles;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: overlap, touch, misses, sweeps, saturation.
        send_beat(make_pair(0, 0, 32, 32, 16, 16, 48, 48, 0, 0, 0, 0));
        send_beat(make_pair(0, 0, 32, 32, 32, 32, 64, 64, 5, 5, 0, 0));
        send_beat(make_pair(0, 0, 16, 16, 64, 0, 80, 16, 0, 0, 0, 0));
        send_beat(make_pair(0, 0, 16, 16, 64, 0, 80, 16, 0, 0, 100, 0));
        send_beat(make_pair(0, 0, 16, 16, 64, 0, 80, 16, 0, 0, -96, 0));
        send_beat(make_pair(0, 0, 16, 16, 64, 0, 80, 16, 0, 0, -48, 0));
        send_beat(make_pair(0, 0, 16, 16, -64, 0, -48, 16, 0, 0, 96, 0));
        send_beat(make_pair(0, 0, 16, 16, 0, 64, 16, 80, 0, 96, 0, 0));
        send_beat(make_pair(0, 0, 16, 16, 64, 64, 80, 80, 0, 0, -96, -48));
        send_beat(make_pair(0, 0, 16, 16, 64, 64, 80, 80, 0, 0, -96, -300));
        send_beat(make_pair(0, 0, 16, 16, 64, 0, 80, 16, 32767, 0, -32768, 0));
        send_beat(make_pair(-32768, -32768, 32767, -32768, 32767, 32767,
                            -32768, 32767, -32768, 32767, 32767, -32768));
        send_beat(make_pair(-32768, -32768, -32768, -32768, 32767, 32767,
                            32767, 32767, -32768, -32768, 32767, 32767));
        send_beat(make_pair(32767, 32767, 32767, 32767, -32768, -32768,
                            -32768, -32768, 32767, 32767, -32768, -32768));
        send_beat(make_pair(10, 10, -10, -10, 50, 50, 60, 60, 0, 0, -64, -64));
        send_beat(make_pair(0, 0, 16, 16, 17, 0, 33, 16, 0, 0, -1, 0));
        send_beat(make_pair(0, 0, 16, 16, 0, 17, 16, 33, 0, 0, 0, 0));
        send_beat(make_pair(-1, -1, -1, -1, 0, 0, 0, 0, -1, -1, -1, -1));

        // Let the pipeline drain once before the random stream.
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        for (int i = 0; i < 1650; i++)
            send_beat(rand_pair());
        start <= 1'b0;

        cycles = 0;
        while (pending != 0 && cycles < 1000)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (30) @(posedge clk);
        if (pending == 0 && fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
